// ===== rtl/core/tlik_pkg.sv =====
// Shared types, constants and tables for the two-link leg inverse kinematics unit.
// Holds the transaction structs, register indexes and the CORDIC arctangent table.
// No dependencies.
`default_nettype none

package tlik_pkg;

    // Input and result transactions
    typedef struct packed {
        logic [15:0]        foot_height;
        logic signed [15:0] foot_reach;
    } in_item_t;

    typedef struct packed {
        logic [7:0] hip_servo_deg;
        logic [7:0] knee_servo_deg;
    } out_item_t;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_UPPER_LINK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_LINK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIP_OFFSET = 2'd2;

    localparam logic [15:0] UPPER_LINK_RESET = 16'd640;
    localparam logic [15:0] LOWER_LINK_RESET = 16'd640;
    localparam logic [12:0] HIP_OFFSET_RESET = 13'd0;

    // Datapath widths
    localparam int SQRT_IN_W  = 62;
    localparam int SQRT_STEPS = 31;
    localparam int DIV_NUM_W  = 42;
    localparam int DIV_DEN_W  = 41;
    localparam int DIV_STEPS  = 30;
    localparam int CORDIC_XW  = 34;
    localparam int CORDIC_ZW  = 33;
    localparam int RAD_W      = 34;

    localparam int CORDIC_ITERATIONS = 16;
    localparam int ATAN_TABLE_LEN    = 24;

    localparam logic signed [31:0]    ONE_Q30         = 32'sd1073741824;
    localparam logic signed [RAD_W-1:0] PI_Q30        = 34'sd3373259426;
    localparam logic [29:0]           DEG_PER_RAD_Q24 = 30'd961263669;

    // atan(2^-i) in Q30 radians
    localparam logic [29:0] ATAN_TABLE [ATAN_TABLE_LEN] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
        30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
        30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
        30'd262144,    30'd131072,    30'd65536,     30'd32768,
        30'd16384,     30'd8192,      30'd4096,      30'd2048,
        30'd1024,      30'd512,       30'd256,       30'd128
    };

endpackage

`default_nettype wire

// ===== rtl/core/tlik_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, floor result.
// Depends on tlik_pkg for widths and step count.
`default_nettype none

module tlik_sqrt (
    input  wire logic                             aclk,
    input  wire logic                             en,
    input  wire logic [tlik_pkg::SQRT_IN_W-1:0]   rad_in,
    output logic      [tlik_pkg::SQRT_STEPS-1:0]  root_out
);

    localparam int N  = tlik_pkg::SQRT_STEPS;
    localparam int IW = tlik_pkg::SQRT_IN_W;
    localparam int RW = N + 2;

    logic [IW-1:0] rad_reg  [N];
    logic [RW-1:0] rem_reg  [N];
    logic [N-1:0]  root_reg [N];
    logic [IW-1:0] rad_next  [N];
    logic [RW-1:0] rem_next  [N];
    logic [N-1:0]  root_next [N];

    for (genvar k = 0; k < N; k++) begin : g_step
        logic [IW-1:0] rad_cur;
        logic [RW-1:0] rem_cur;
        logic [N-1:0]  root_cur;
        logic [RW+2:0] trial;
        if (k == 0) begin : g_first
            assign rad_cur  = rad_in;
            assign rem_cur  = '0;
            assign root_cur = '0;
        end else begin : g_next
            assign rad_cur  = rad_reg[k-1];
            assign rem_cur  = rem_reg[k-1];
            assign root_cur = root_reg[k-1];
        end
        // try (4*rem + pair) - (4*root + 1)
        assign trial = {1'b0, rem_cur, rad_cur[IW-1 -: 2]}
                     - {3'b0, root_cur, 2'b01};
        assign rad_next[k]  = {rad_cur[IW-3:0], 2'b00};
        assign rem_next[k]  = trial[RW+2] ? {rem_cur[RW-3:0], rad_cur[IW-1 -: 2]}
                                          : trial[RW-1:0];
        assign root_next[k] = {root_cur[N-2:0], ~trial[RW+2]};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < N; k++) begin
                rad_reg[k]  <= rad_next[k];
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
            end
        end
    end

    assign root_out = root_reg[N-1];

endmodule

`default_nettype wire

// ===== rtl/core/tlik_div.sv =====
// Pipelined restoring divider giving a Q30 cosine argument saturated to +-1.
// Depends on tlik_pkg for widths and step count.
`default_nettype none

module tlik_div (
    input  wire logic                                   aclk,
    input  wire logic                                   en,
    input  wire logic signed [tlik_pkg::DIV_NUM_W-1:0]  num_in,
    input  wire logic        [tlik_pkg::DIV_DEN_W-1:0]  den_in,
    output logic signed      [31:0]                     arg_out
);

    localparam int N  = tlik_pkg::DIV_STEPS;
    localparam int AW = tlik_pkg::DIV_NUM_W;
    localparam int DW = tlik_pkg::DIV_DEN_W;

    logic [AW-1:0] a_reg   [N+1];
    logic [DW-1:0] den_reg [N+1];
    logic [N-1:0]  q_reg   [N+1];
    logic          neg_reg [N+1];
    logic          sat_reg [N+1];
    logic [AW-1:0] a_next  [N+1];
    logic [N-1:0]  q_next  [N+1];

    logic [AW-1:0] mag0;
    logic          sat0;

    assign mag0      = num_in[AW-1] ? AW'(-num_in) : AW'(num_in);
    assign sat0      = mag0 >= {1'b0, den_in};
    assign a_next[0] = mag0;
    assign q_next[0] = '0;

    for (genvar k = 1; k <= N; k++) begin : g_step
        logic [AW:0] a2;
        logic        ge;
        assign a2        = {a_reg[k-1], 1'b0};
        assign ge        = a2 >= {2'b0, den_reg[k-1]};
        assign a_next[k] = ge ? AW'(a2 - {2'b0, den_reg[k-1]}) : a2[AW-1:0];
        assign q_next[k] = {q_reg[k-1][N-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg[0] <= den_in;
            neg_reg[0] <= num_in[AW-1];
            sat_reg[0] <= sat0;
            for (int k = 0; k <= N; k++) begin
                a_reg[k] <= a_next[k];
                q_reg[k] <= q_next[k];
            end
            for (int k = 1; k <= N; k++) begin
                den_reg[k] <= den_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                sat_reg[k] <= sat_reg[k-1];
            end
        end
    end

    always_comb begin
        if (sat_reg[N]) begin
            arg_out = neg_reg[N] ? -tlik_pkg::ONE_Q30 : tlik_pkg::ONE_Q30;
        end else if (neg_reg[N]) begin
            arg_out = -$signed({2'b00, q_reg[N]});
        end else begin
            arg_out = $signed({2'b00, q_reg[N]});
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/tlik_cordic.sv =====
// Pipelined vectoring CORDIC: atan2(y, x) for x >= 0 in Q30 radians.
// One iteration per stage. Depends on tlik_pkg for the arctangent table.
`default_nettype none

module tlik_cordic (
    input  wire logic                                   aclk,
    input  wire logic                                   en,
    input  wire logic signed [tlik_pkg::CORDIC_XW-1:0]  x_in,
    input  wire logic signed [tlik_pkg::CORDIC_XW-1:0]  y_in,
    output logic signed      [tlik_pkg::CORDIC_ZW-1:0]  z_out
);

    localparam int N  = tlik_pkg::CORDIC_ITERATIONS;
    localparam int XW = tlik_pkg::CORDIC_XW;
    localparam int ZW = tlik_pkg::CORDIC_ZW;

    logic signed [XW-1:0] x_reg  [N];
    logic signed [XW-1:0] y_reg  [N];
    logic signed [ZW-1:0] z_reg  [N];
    logic                 zf_reg [N];
    logic signed [XW-1:0] x_next [N];
    logic signed [XW-1:0] y_next [N];
    logic signed [ZW-1:0] z_next [N];
    logic                 zf_next [N];

    for (genvar i = 0; i < N; i++) begin : g_iter
        logic signed [XW-1:0] x_cur;
        logic signed [XW-1:0] y_cur;
        logic signed [ZW-1:0] z_cur;
        logic signed [ZW-1:0] step;
        logic                 up;
        if (i == 0) begin : g_first
            assign x_cur      = x_in;
            assign y_cur      = y_in;
            assign z_cur      = '0;
            assign zf_next[i] = (y_in == '0);
        end else begin : g_next
            assign x_cur      = x_reg[i-1];
            assign y_cur      = y_reg[i-1];
            assign z_cur      = z_reg[i-1];
            assign zf_next[i] = zf_reg[i-1];
        end
        assign step      = $signed({3'b000, tlik_pkg::ATAN_TABLE[i]});
        assign up        = y_cur > 0;
        assign x_next[i] = up ? x_cur + (y_cur >>> i) : x_cur - (y_cur >>> i);
        assign y_next[i] = up ? y_cur - (x_cur >>> i) : y_cur + (x_cur >>> i);
        assign z_next[i] = up ? z_cur + step : z_cur - step;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < N; i++) begin
                x_reg[i]  <= x_next[i];
                y_reg[i]  <= y_next[i];
                z_reg[i]  <= z_next[i];
                zf_reg[i] <= zf_next[i];
            end
        end
    end

    // a zero y component gives a zero angle
    assign z_out = zf_reg[N-1] ? '0 : z_reg[N-1];

endmodule

`default_nettype wire

// ===== rtl/core/tlik_acos.sv =====
// Pipelined arccosine of a Q30 argument: atan2(sqrt(1 - c^2), |c|), mirrored for c < 0.
// Depends on tlik_pkg, tlik_sqrt and tlik_cordic.
`default_nettype none

module tlik_acos (
    input  wire logic                               aclk,
    input  wire logic                               en,
    input  wire logic signed [31:0]                 arg_in,
    output logic signed      [tlik_pkg::RAD_W-1:0]  rad_out
);

    localparam int SQ = tlik_pkg::SQRT_STEPS;
    localparam int N  = tlik_pkg::CORDIC_ITERATIONS;
    localparam int DL = SQ + N;

    logic [30:0] cc_reg;
    logic        neg_reg;
    logic [61:0] sq_reg;
    logic [30:0] cc1_reg;
    logic        neg1_reg;
    logic [30:0] cc_dly_reg  [SQ];
    logic        neg_dly_reg [DL];
    logic signed [tlik_pkg::RAD_W-1:0] rad_reg;

    logic [SQ-1:0]                          root;
    logic signed [tlik_pkg::CORDIC_ZW-1:0]  ang;

    always_ff @(posedge aclk) begin
        if (en) begin
            cc_reg   <= arg_in[31] ? 31'(-arg_in) : arg_in[30:0];
            neg_reg  <= arg_in[31];
            sq_reg   <= 62'(cc_reg) * 62'(cc_reg);
            cc1_reg  <= cc_reg;
            neg1_reg <= neg_reg;
            cc_dly_reg[0]  <= cc1_reg;
            neg_dly_reg[0] <= neg1_reg;
            for (int i = 1; i < SQ; i++) begin
                cc_dly_reg[i] <= cc_dly_reg[i-1];
            end
            for (int i = 1; i < DL; i++) begin
                neg_dly_reg[i] <= neg_dly_reg[i-1];
            end
            rad_reg <= neg_dly_reg[DL-1] ? tlik_pkg::PI_Q30 - tlik_pkg::RAD_W'(ang)
                                         : tlik_pkg::RAD_W'(ang);
        end
    end

    tlik_sqrt u_sqrt (
        .aclk     (aclk),
        .en       (en),
        .rad_in   ((62'd1 << 60) - sq_reg),
        .root_out (root)
    );

    tlik_cordic u_cordic (
        .aclk  (aclk),
        .en    (en),
        .x_in  ($signed({3'b000, cc_dly_reg[SQ-1]})),
        .y_in  ($signed({3'b000, root})),
        .z_out (ang)
    );

    assign rad_out = rad_reg;

endmodule

`default_nettype wire

// ===== rtl/core/two_link_leg_inverse_kinematics_unit.sv =====
// Two-link leg inverse kinematics unit, top level.
// Input channel s_* carries a foot target (height below hip, signed reach), result
// channel m_* carries hip and knee servo angles in whole degrees, both valid/ready.
// The configuration port writes the upper and lower link lengths (Q10.6) and the hip
// offset (Q8.4 degrees); write it only while no transaction is in flight.
// The datapath is a fixed-depth pipeline: one transaction is accepted every cycle
// unless a held result stalls it. The distance square root, the divider, the
// arccosine square root and CORDIC make up most of its depth.
// When m_ready is low while a result is held, the whole pipeline holds and s_ready
// drops; nothing is lost or repeated. Bubbles in the pipe drain freely.
// Reset (aresetn low, synchronous) empties the pipeline and loads the default link
// lengths (640 = 10.0) and a zero hip offset.
// Depends on tlik_pkg, tlik_sqrt, tlik_div, tlik_acos and tlik_cordic.
`default_nettype none

module two_link_leg_inverse_kinematics_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire tlik_pkg::in_item_t                s_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output tlik_pkg::out_item_t                    m_data,
    input  wire logic                              cfg_wr_en,
    input  wire logic [tlik_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [tlik_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int SQ       = tlik_pkg::SQRT_STEPS;
    localparam int N        = tlik_pkg::CORDIC_ITERATIONS;
    localparam int DIV_LAT  = tlik_pkg::DIV_STEPS + 1;
    localparam int ACOS_LAT = SQ + N + 3;
    localparam int ACOS_AT  = SQ + 1 + DIV_LAT + ACOS_LAT;
    localparam int ATAN_DL  = ACOS_AT - N;
    localparam int TOTAL    = ACOS_AT + 4;
    localparam int RW       = tlik_pkg::RAD_W;

    // configuration registers
    logic [15:0]        upper_reg;
    logic [15:0]        lower_reg;
    logic signed [12:0] offset_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upper_reg  <= tlik_pkg::UPPER_LINK_RESET;
            lower_reg  <= tlik_pkg::LOWER_LINK_RESET;
            offset_reg <= tlik_pkg::HIP_OFFSET_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                tlik_pkg::REG_UPPER_LINK: upper_reg  <= cfg_wdata;
                tlik_pkg::REG_LOWER_LINK: lower_reg  <= cfg_wdata;
                tlik_pkg::REG_HIP_OFFSET: offset_reg <= cfg_wdata[12:0];
                default: ;
            endcase
        end
    end

    // pipeline advance: hold everything while a result waits
    logic             en;
    logic [TOTAL-1:0] valid_reg;

    assign en      = !m_valid || m_ready;
    assign s_ready = en;
    assign m_valid = valid_reg[TOTAL-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[TOTAL-2:0], s_valid};
        end
    end

    // stage 1: squares and link product
    logic [15:0]        h1_reg;
    logic signed [15:0] r1_reg;
    logic [30:0]        rsq_reg;
    logic [31:0]        hsq_reg;
    logic [31:0]        usq_reg;
    logic [31:0]        lsq_reg;
    logic [31:0]        ul_reg;
    logic signed [31:0] rsq_full;

    assign rsq_full = s_data.foot_reach * s_data.foot_reach;

    always_ff @(posedge aclk) begin
        if (en) begin
            h1_reg  <= s_data.foot_height;
            r1_reg  <= s_data.foot_reach;
            rsq_reg <= rsq_full[30:0];
            hsq_reg <= 32'(s_data.foot_height) * 32'(s_data.foot_height);
            usq_reg <= 32'(upper_reg) * 32'(upper_reg);
            lsq_reg <= 32'(lower_reg) * 32'(lower_reg);
            ul_reg  <= 32'(upper_reg) * 32'(lower_reg);
        end
    end

    // stage 2: squared distance and cosine numerators
    logic [15:0]        h2_reg;
    logic signed [15:0] r2_reg;
    logic [32:0]        d2_reg;
    logic               dz_reg;
    logic signed [34:0] knum_reg;
    logic signed [34:0] hnum_reg;
    logic [32:0]        kden_reg;
    logic [32:0]        d2_sum;

    assign d2_sum = 33'(rsq_reg) + 33'(hsq_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            h2_reg   <= h1_reg;
            r2_reg   <= r1_reg;
            d2_reg   <= d2_sum;
            dz_reg   <= (d2_sum == '0);
            knum_reg <= $signed({3'b000, usq_reg}) + $signed({3'b000, lsq_reg})
                      - $signed({2'b00, d2_sum});
            hnum_reg <= $signed({3'b000, usq_reg}) + $signed({2'b00, d2_sum})
                      - $signed({3'b000, lsq_reg});
            kden_reg <= {ul_reg, 1'b0};
        end
    end

    // distance root, side data waits alongside
    logic [SQ-1:0]      d_root;
    logic signed [34:0] knum_dly_reg [SQ];
    logic signed [34:0] hnum_dly_reg [SQ];
    logic [32:0]        kden_dly_reg [SQ];

    tlik_sqrt u_dist_sqrt (
        .aclk     (aclk),
        .en       (en),
        .rad_in   ({17'd0, d2_reg, 12'd0}),
        .root_out (d_root)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            knum_dly_reg[0] <= knum_reg;
            hnum_dly_reg[0] <= hnum_reg;
            kden_dly_reg[0] <= kden_reg;
            for (int i = 1; i < SQ; i++) begin
                knum_dly_reg[i] <= knum_dly_reg[i-1];
                hnum_dly_reg[i] <= hnum_dly_reg[i-1];
                kden_dly_reg[i] <= kden_dly_reg[i-1];
            end
        end
    end

    // stage after root: hip denominator 2*U*d
    logic [39:0]        hden_reg;
    logic signed [34:0] knum3_reg;
    logic signed [34:0] hnum3_reg;
    logic [32:0]        kden3_reg;
    logic [38:0]        ud_prod;

    assign ud_prod = 39'(upper_reg) * 39'(d_root[22:0]);

    always_ff @(posedge aclk) begin
        if (en) begin
            hden_reg  <= {ud_prod, 1'b0};
            knum3_reg <= knum_dly_reg[SQ-1];
            hnum3_reg <= hnum_dly_reg[SQ-1];
            kden3_reg <= kden_dly_reg[SQ-1];
        end
    end

    // cosine arguments
    logic signed [31:0] hip_arg;
    logic signed [31:0] knee_cos;

    tlik_div u_hip_div (
        .aclk    (aclk),
        .en      (en),
        .num_in  ($signed({hnum3_reg[34], hnum3_reg, 6'b000000})),
        .den_in  ({1'b0, hden_reg}),
        .arg_out (hip_arg)
    );

    tlik_div u_knee_div (
        .aclk    (aclk),
        .en      (en),
        .num_in  ($signed({{7{knum3_reg[34]}}, knum3_reg})),
        .den_in  ({8'd0, kden3_reg}),
        .arg_out (knee_cos)
    );

    logic signed [RW-1:0] hip_acos;
    logic signed [RW-1:0] knee_acos;

    tlik_acos u_hip_acos (
        .aclk    (aclk),
        .en      (en),
        .arg_in  (hip_arg),
        .rad_out (hip_acos)
    );

    tlik_acos u_knee_acos (
        .aclk    (aclk),
        .en      (en),
        .arg_in  (knee_cos),
        .rad_out (knee_acos)
    );

    // direction of the foot, then wait for the arccosines
    logic signed [tlik_pkg::CORDIC_ZW-1:0] dir_ang;
    logic signed [tlik_pkg::CORDIC_ZW-1:0] dir_dly_reg [ATAN_DL];
    logic                                  dz_dly_reg  [ACOS_AT];

    tlik_cordic u_dir_cordic (
        .aclk  (aclk),
        .en    (en),
        .x_in  ($signed({4'b0000, h2_reg, 14'd0})),
        .y_in  ($signed({{4{r2_reg[15]}}, r2_reg, 14'd0})),
        .z_out (dir_ang)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            dir_dly_reg[0] <= dir_ang;
            dz_dly_reg[0]  <= dz_reg;
            for (int i = 1; i < ATAN_DL; i++) begin
                dir_dly_reg[i] <= dir_dly_reg[i-1];
            end
            for (int i = 1; i < ACOS_AT; i++) begin
                dz_dly_reg[i] <= dz_dly_reg[i-1];
            end
        end
    end

    // radians to degrees, product split in two halves
    logic signed [RW-1:0] hip_rad;
    logic signed [30:0]   k_signed;
    logic signed [47:0]   hlo_reg;
    logic signed [47:0]   hhi_reg;
    logic signed [47:0]   klo_reg;
    logic signed [47:0]   khi_reg;

    assign k_signed = $signed({1'b0, tlik_pkg::DEG_PER_RAD_Q24});
    assign hip_rad  = dz_dly_reg[ACOS_AT-1] ? '0
                    : RW'(dir_dly_reg[ATAN_DL-1]) + hip_acos;

    always_ff @(posedge aclk) begin
        if (en) begin
            hlo_reg <= $signed({1'b0, hip_rad[16:0]}) * k_signed;
            hhi_reg <= $signed(hip_rad[RW-1:17]) * k_signed;
            klo_reg <= $signed({1'b0, knee_acos[16:0]}) * k_signed;
            khi_reg <= $signed(knee_acos[RW-1:17]) * k_signed;
        end
    end

    // final: degrees, offset, clamps
    logic signed [65:0] hprod;
    logic signed [65:0] kprod;
    logic signed [35:0] hval;
    logic signed [11:0] kdeg;
    logic [7:0]         hip_deg;
    logic [7:0]         knee_angle;
    tlik_pkg::out_item_t m_data_reg;

    assign hprod = $signed({hhi_reg, 17'd0}) + hlo_reg;
    assign kprod = $signed({khi_reg, 17'd0}) + klo_reg;
    assign hval  = 36'sd94371840 - 36'($signed(hprod[65:34]))
                 + 36'($signed({offset_reg, 16'd0}));
    assign kdeg  = kprod[65:54];

    always_comb begin
        if (hval[35]) begin
            hip_deg = 8'd0;
        end else if (hval[35:20] > 16'd180) begin
            hip_deg = 8'd180;
        end else begin
            hip_deg = hval[27:20];
        end
        if (kdeg > 12'sd180) begin
            knee_angle = 8'd0;
        end else begin
            knee_angle = 8'(12'sd180 - kdeg);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg.hip_servo_deg  <= hip_deg;
            m_data_reg.knee_servo_deg <= knee_angle;
        end
    end

    assign m_data = m_data_reg;

`ifndef ASSERT_OFF
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> valid_reg[0])
        else $error("accepted transaction did not enter the pipeline");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(valid_reg))
        else $error("pipeline moved while stalled");

    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !valid_reg[TOTAL-2]) |=> !m_valid)
        else $error("result repeated after it was taken");

    a_hip_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.hip_servo_deg <= 8'd180))
        else $error("hip angle out of range");
`endif

endmodule

`default_nettype wire
